### design/chm_pkg.sv
`timescale 1ns / 1ps

package chm_pkg;

    // sizing defaults
    localparam int MAX_BUCKETS_DEF = 8192;
    localparam int MAX_NODES_DEF   = 6144;
    localparam int DEFAULT_BUCKETS = 509;
    localparam int INIT_W          = 13;
    localparam int COUNT_W         = 13;
    localparam int HASH_LAST       = 5;

    // mixing hash constants
    localparam logic [31:0] HC0 = 32'h7ed55d16;
    localparam logic [31:0] HC1 = 32'hc761c23c;
    localparam logic [31:0] HC2 = 32'h165667b1;
    localparam logic [31:0] HC3 = 32'hd3a2646c;
    localparam logic [31:0] HC4 = 32'hfd7046c5;
    localparam logic [31:0] HC5 = 32'hb55a4f09;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_ROOM = 1'b1;

    typedef enum logic [1:0] {
        K_PUT    = 2'd0,
        K_GET    = 2'd1,
        K_REMOVE = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic [12:0] entry_count;
        logic        status;
    } t_out;

    // command handed from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] hash;
    } t_cmd;

    typedef enum logic [4:0] {
        S_INIT_SWEEP,
        S_IDLE,
        S_CLR_SWEEP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_HEAD_RD,
        S_HEAD_WT,
        S_WALK,
        S_NODE_WT,
        S_DECIDE,
        S_POP_WT,
        S_RG_CLR,
        S_RG_HRD,
        S_RG_HWT,
        S_RG_NODE,
        S_RG_NWT,
        S_RG_DIV,
        S_RG_HD,
        S_RG_HDW
    } t_state;

    // one step of the six-step integer mixing hash
    function automatic logic [31:0] mix_step(input logic [31:0] a, input logic [2:0] step);
        logic [31:0] r;
        case (step)
            3'd0:    r = a + HC0 + (a << 12);
            3'd1:    r = a ^ HC1 ^ (a >> 19);
            3'd2:    r = a + HC2 + (a << 5);
            3'd3:    r = (a + HC3) ^ (a << 9);
            3'd4:    r = a + HC4 + (a << 3);
            3'd5:    r = a ^ HC5 ^ (a >> 16);
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

### design/chm_ram.sv
`timescale 1ns / 1ps

module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### design/chm_front.sv
`timescale 1ns / 1ps

module chm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_hold,
    input  chm_pkg::t_in  i_in,
    output logic          o_busy,
    output logic          o_q_valid,
    output chm_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);

    logic          r_hashing;
    logic [2:0]    r_step;
    chm_pkg::t_cmd r_cmd;
    chm_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          accept;
    logic          push;
    logic [31:0]   hash_nx;

    assign o_busy    = r_hashing | (r_cnt == 2'd2) | i_hold;
    assign accept    = i_start & ~o_busy;
    assign push      = r_hashing & (r_step == 3'(chm_pkg::HASH_LAST));
    assign hash_nx   = chm_pkg::mix_step(r_cmd.hash, r_step);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    // hash sequencer and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hashing <= 1'b0;
            r_step    <= 3'd0;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_cnt     <= 2'd0;
        end else begin
            if (accept) begin
                r_hashing <= 1'b1;
                r_step    <= 3'd0;
            end else if (r_hashing) begin
                if (push) begin
                    r_hashing <= 1'b0;
                end
                r_step <= r_step + 3'd1;
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    // command payload and queue storage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.kind  <= i_in.kind;
            r_cmd.key   <= i_in.key;
            r_cmd.value <= i_in.value;
            r_cmd.hash  <= i_in.key;
        end else if (r_hashing) begin
            r_cmd.hash <= hash_nx;
        end
        if (push) begin
            r_q[r_wp] <= '{kind: r_cmd.kind, key: r_cmd.key, value: r_cmd.value,
                           hash: hash_nx};
        end
    end

endmodule

### design/chm_div.sv
`timescale 1ns / 1ps

module chm_div #(
    parameter int DW = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_rem
);

    logic          r_run;
    logic [4:0]    r_cnt;
    logic [31:0]   r_quo;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial  = {r_rem, r_quo[31]};
    assign diff   = trial - {1'b0, r_den};
    assign o_rem  = r_rem;

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= 5'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_quo <= {r_quo[30:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                r_rem <= diff[DW-1:0];
            end else begin
                r_rem <= trial[DW-1:0];
            end
        end
    end

endmodule

### design/chm_back.sv
`timescale 1ns / 1ps

module chm_back #(
    parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_NODES   = chm_pkg::MAX_NODES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [chm_pkg::INIT_W-1:0]   i_init_buckets,
    input  logic                         i_q_valid,
    input  chm_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_init,
    output logic                         o_res_valid,
    output chm_pkg::t_out                o_res
);

    localparam int BA        = $clog2(MAX_BUCKETS);
    localparam int CW        = $clog2(MAX_BUCKETS + 1);
    localparam int NA        = $clog2(MAX_NODES);
    localparam int NW        = $clog2(MAX_NODES + 1);
    localparam int SWEEP_LEN = (MAX_BUCKETS > MAX_NODES) ? MAX_BUCKETS : MAX_NODES;
    localparam int SW        = $clog2(SWEEP_LEN + 1);
    localparam int CNT_W     = chm_pkg::COUNT_W;
    localparam int RESET_BC  = (chm_pkg::DEFAULT_BUCKETS > MAX_BUCKETS) ? MAX_BUCKETS
                                                                        : chm_pkg::DEFAULT_BUCKETS;
    localparam logic [NW-1:0] NIL = NW'(MAX_NODES);

    chm_pkg::t_state r_state, n_state;
    chm_pkg::t_cmd   r_cmd;
    logic            r_bank;
    logic [CW-1:0]   r_bc;
    logic [CW-1:0]   r_grown;
    logic [NW-1:0]   r_used;
    logic [SW-1:0]   r_sweep;
    logic [BA-1:0]   r_bucket;
    logic [NW-1:0]   r_p, r_prev, r_node, r_link, r_head;
    logic [31:0]     r_val;
    logic            r_found;
    logic [CW-1:0]   r_c;
    logic [NW-1:0]   r_n, r_next;
    logic [BA-1:0]   r_nb;
    logic            r_hd_rsel;
    logic            r_res_valid;
    chm_pkg::t_out   r_res;

    // memory controls
    logic            hd_we, hd_wbank, hd_rbank;
    logic [BA-1:0]   hd_waddr, hd_raddr;
    logic [NW-1:0]   hd_wdata, hd_q, hd_q0, hd_q1;
    logic [NA-1:0]   nd_raddr, nd_waddr;
    logic            key_we, val_we, hsh_we, lnk_we;
    logic [NW-1:0]   lnk_wdata;
    logic [31:0]     key_q, val_q, hsh_q;
    logic [NW-1:0]   lnk_q;
    logic            fs_we;
    logic [NA-1:0]   fs_waddr, fs_raddr;
    logic [NW-1:0]   fs_wdata, fs_q;
    logic            div_start, div_done;
    logic [31:0]     div_dividend;
    logic [CW-1:0]   div_divisor, div_rem;
    logic            emit;
    chm_pkg::t_out   res_n;

    // decisions
    logic [31:0]     start32;
    logic [CW-1:0]   start_bc;
    logic            sweep_end, rgclr_end, last_c;
    logic            match;
    logic            is_put_new, full, grow_need, grow_fail;
    logic            no_room, do_grow, do_insert;
    logic [31:0]     grown32;
    logic [NW-1:0]   ins_node;

    assign start32   = (i_init_buckets == '0) ? 32'(chm_pkg::DEFAULT_BUCKETS)
                                              : 32'(i_init_buckets);
    assign start_bc  = (start32 > 32'(MAX_BUCKETS)) ? CW'(MAX_BUCKETS) : CW'(start32);
    assign sweep_end = (r_sweep == SW'(SWEEP_LEN - 1));
    assign rgclr_end = (32'(r_sweep) == 32'(r_grown) - 32'd1);
    assign last_c    = (32'(r_c) == 32'(r_bc) - 32'd1);
    assign match     = (key_q == r_cmd.key);
    assign hd_q      = r_hd_rsel ? hd_q1 : hd_q0;

    assign grown32    = (32'(r_bc) << 1) + 32'd1;
    assign is_put_new = (r_cmd.kind == chm_pkg::K_PUT) & ~r_found;
    assign full       = (32'(r_used) >= 32'(MAX_NODES));
    assign grow_need  = (32'(r_used) + 32'd1) > ((32'(r_bc) * 32'd3) >> 2);
    assign grow_fail  = (grown32 > 32'(MAX_BUCKETS));
    assign no_room    = is_put_new & (full | (grow_need & grow_fail));
    assign do_grow    = is_put_new & ~full & grow_need & ~grow_fail;
    assign do_insert  = is_put_new & ~full & ~grow_need;
    assign ins_node   = (fs_q >= NIL) ? '0 : fs_q;

    assign o_init      = (r_state == chm_pkg::S_INIT_SWEEP);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chm_pkg::S_INIT_SWEEP,
            chm_pkg::S_CLR_SWEEP: begin
                if (sweep_end) n_state = chm_pkg::S_IDLE;
            end
            chm_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_cmd.kind == chm_pkg::K_CLEAR) ? chm_pkg::S_CLR_SWEEP
                                                                  : chm_pkg::S_DIV_GO;
                end
            end
            chm_pkg::S_DIV_GO:   n_state = chm_pkg::S_DIV_WAIT;
            chm_pkg::S_DIV_WAIT: begin
                if (div_done) n_state = chm_pkg::S_HEAD_RD;
            end
            chm_pkg::S_HEAD_RD:  n_state = chm_pkg::S_HEAD_WT;
            chm_pkg::S_HEAD_WT:  n_state = chm_pkg::S_WALK;
            chm_pkg::S_WALK: begin
                n_state = (r_p == NIL) ? chm_pkg::S_DECIDE : chm_pkg::S_NODE_WT;
            end
            chm_pkg::S_NODE_WT: begin
                n_state = match ? chm_pkg::S_DECIDE : chm_pkg::S_WALK;
            end
            chm_pkg::S_DECIDE: begin
                if (do_insert)    n_state = chm_pkg::S_POP_WT;
                else if (do_grow) n_state = chm_pkg::S_RG_CLR;
                else              n_state = chm_pkg::S_IDLE;
            end
            chm_pkg::S_POP_WT:   n_state = chm_pkg::S_IDLE;
            chm_pkg::S_RG_CLR: begin
                if (rgclr_end) n_state = chm_pkg::S_RG_HRD;
            end
            chm_pkg::S_RG_HRD:   n_state = chm_pkg::S_RG_HWT;
            chm_pkg::S_RG_HWT:   n_state = chm_pkg::S_RG_NODE;
            chm_pkg::S_RG_NODE: begin
                if (r_n != NIL)  n_state = chm_pkg::S_RG_NWT;
                else if (last_c) n_state = chm_pkg::S_DIV_GO;
                else             n_state = chm_pkg::S_RG_HRD;
            end
            chm_pkg::S_RG_NWT:   n_state = chm_pkg::S_RG_DIV;
            chm_pkg::S_RG_DIV: begin
                if (div_done) n_state = chm_pkg::S_RG_HD;
            end
            chm_pkg::S_RG_HD:    n_state = chm_pkg::S_RG_HDW;
            chm_pkg::S_RG_HDW:   n_state = chm_pkg::S_RG_NODE;
            default:             n_state = chm_pkg::S_IDLE;
        endcase
    end

    // memory strobes, divider start and result
    always_comb begin
        hd_we        = 1'b0;
        hd_wbank     = r_bank;
        hd_waddr     = r_bucket;
        hd_wdata     = NIL;
        hd_rbank     = r_bank;
        hd_raddr     = r_bucket;
        nd_raddr     = r_p[NA-1:0];
        nd_waddr     = r_node[NA-1:0];
        key_we       = 1'b0;
        val_we       = 1'b0;
        hsh_we       = 1'b0;
        lnk_we       = 1'b0;
        lnk_wdata    = r_head;
        fs_we        = 1'b0;
        fs_waddr     = r_sweep[NA-1:0];
        fs_wdata     = NW'(SW'(MAX_NODES - 1) - r_sweep);
        fs_raddr     = NA'(32'(MAX_NODES - 1) - 32'(r_used));
        div_start    = 1'b0;
        div_dividend = r_cmd.hash;
        div_divisor  = r_bc;
        o_q_pop      = 1'b0;
        emit         = 1'b0;
        res_n.found       = r_found;
        res_n.read_value  = '0;
        res_n.entry_count = CNT_W'(r_used);
        res_n.status      = chm_pkg::STATUS_OK;
        case (r_state)
            chm_pkg::S_INIT_SWEEP,
            chm_pkg::S_CLR_SWEEP: begin
                hd_we    = (32'(r_sweep) < 32'(MAX_BUCKETS));
                hd_waddr = r_sweep[BA-1:0];
                fs_we    = (32'(r_sweep) < 32'(MAX_NODES));
                if (sweep_end && r_state == chm_pkg::S_CLR_SWEEP) begin
                    emit              = 1'b1;
                    res_n.found       = 1'b0;
                    res_n.entry_count = '0;
                end
            end
            chm_pkg::S_IDLE: begin
                o_q_pop = i_q_valid;
            end
            chm_pkg::S_DIV_GO: begin
                div_start = 1'b1;
            end
            chm_pkg::S_DECIDE: begin
                if (r_cmd.kind == chm_pkg::K_GET) begin
                    emit = 1'b1;
                    if (r_found) res_n.read_value = r_val;
                end else if (r_cmd.kind == chm_pkg::K_REMOVE) begin
                    emit = 1'b1;
                    if (r_found) begin
                        // unlink from predecessor or bucket head
                        if (r_prev != NIL) begin
                            lnk_we    = 1'b1;
                            nd_waddr  = r_prev[NA-1:0];
                            lnk_wdata = r_link;
                        end else begin
                            hd_we    = 1'b1;
                            hd_wdata = r_link;
                        end
                        fs_we             = 1'b1;
                        fs_waddr          = NA'(32'(MAX_NODES) - 32'(r_used));
                        fs_wdata          = r_node;
                        res_n.entry_count = CNT_W'(r_used - NW'(1));
                    end
                end else if (r_found) begin
                    emit   = 1'b1;
                    val_we = 1'b1;
                end else if (no_room) begin
                    emit         = 1'b1;
                    res_n.status = chm_pkg::STATUS_NO_ROOM;
                end
            end
            chm_pkg::S_POP_WT: begin
                // link the popped node at the chain head
                nd_waddr          = ins_node[NA-1:0];
                key_we            = 1'b1;
                val_we            = 1'b1;
                hsh_we            = 1'b1;
                lnk_we            = 1'b1;
                lnk_wdata         = r_head;
                hd_we             = 1'b1;
                hd_wdata          = ins_node;
                emit              = 1'b1;
                res_n.found       = 1'b0;
                res_n.entry_count = CNT_W'(r_used + NW'(1));
            end
            chm_pkg::S_RG_CLR: begin
                hd_we    = 1'b1;
                hd_wbank = ~r_bank;
                hd_waddr = r_sweep[BA-1:0];
            end
            chm_pkg::S_RG_HRD: begin
                hd_raddr = r_c[BA-1:0];
            end
            chm_pkg::S_RG_NODE: begin
                nd_raddr = r_n[NA-1:0];
            end
            chm_pkg::S_RG_NWT: begin
                div_start    = 1'b1;
                div_dividend = hsh_q;
                div_divisor  = r_grown;
            end
            chm_pkg::S_RG_HD: begin
                hd_rbank = ~r_bank;
                hd_raddr = r_nb;
            end
            chm_pkg::S_RG_HDW: begin
                lnk_we    = 1'b1;
                nd_waddr  = r_n[NA-1:0];
                lnk_wdata = hd_q;
                hd_we     = 1'b1;
                hd_wbank  = ~r_bank;
                hd_waddr  = r_nb;
                hd_wdata  = r_n;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chm_pkg::S_INIT_SWEEP;
            r_sweep     <= '0;
            r_bank      <= 1'b0;
            r_used      <= '0;
            r_bc        <= CW'(RESET_BC);
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= emit;
            case (r_state)
                chm_pkg::S_INIT_SWEEP,
                chm_pkg::S_CLR_SWEEP: begin
                    if (sweep_end) begin
                        r_sweep <= '0;
                        r_used  <= '0;
                        // of the two sweeps, only a clear reloads the bucket count
                        if (r_state == chm_pkg::S_CLR_SWEEP) begin
                            r_bc <= start_bc;
                        end
                    end else begin
                        r_sweep <= r_sweep + SW'(1);
                    end
                end
                chm_pkg::S_DECIDE: begin
                    if (r_cmd.kind == chm_pkg::K_REMOVE && r_found) begin
                        r_used <= r_used - NW'(1);
                    end
                    if (do_grow) begin
                        r_sweep <= '0;
                    end
                end
                chm_pkg::S_POP_WT: begin
                    r_used <= r_used + NW'(1);
                end
                chm_pkg::S_RG_CLR: begin
                    r_sweep <= rgclr_end ? '0 : r_sweep + SW'(1);
                end
                chm_pkg::S_RG_NODE: begin
                    if (r_n == NIL && last_c) begin
                        r_bank <= ~r_bank;
                        r_bc   <= r_grown;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_hd_rsel <= hd_rbank;
        if (emit) begin
            r_res <= res_n;
        end
        case (r_state)
            chm_pkg::S_IDLE: begin
                if (i_q_valid) r_cmd <= i_q_cmd;
            end
            chm_pkg::S_DIV_WAIT: begin
                if (div_done) r_bucket <= div_rem[BA-1:0];
            end
            chm_pkg::S_HEAD_WT: begin
                r_p     <= hd_q;
                r_head  <= hd_q;
                r_prev  <= NIL;
                r_found <= 1'b0;
            end
            chm_pkg::S_NODE_WT: begin
                if (match) begin
                    r_found <= 1'b1;
                    r_node  <= r_p;
                    r_link  <= lnk_q;
                    r_val   <= val_q;
                end else begin
                    r_prev <= r_p;
                    r_p    <= lnk_q;
                end
            end
            chm_pkg::S_DECIDE: begin
                r_grown <= CW'(grown32);
            end
            chm_pkg::S_POP_WT: begin
                r_node <= ins_node;
            end
            chm_pkg::S_RG_CLR: begin
                r_c <= '0;
            end
            chm_pkg::S_RG_HWT: begin
                r_n <= hd_q;
            end
            chm_pkg::S_RG_NODE: begin
                if (r_n == NIL) r_c <= r_c + CW'(1);
            end
            chm_pkg::S_RG_NWT: begin
                r_next <= lnk_q;
            end
            chm_pkg::S_RG_DIV: begin
                if (div_done) r_nb <= div_rem[BA-1:0];
            end
            chm_pkg::S_RG_HDW: begin
                r_n <= r_next;
            end
            default: begin
            end
        endcase
    end

    chm_div #(.DW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // two bucket head banks, swapped on every growth
    chm_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_heads0 (
        .i_clk(i_clk), .i_we(hd_we & ~hd_wbank), .i_waddr(hd_waddr),
        .i_wdata(hd_wdata), .i_raddr(hd_raddr), .o_rdata(hd_q0)
    );
    chm_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_heads1 (
        .i_clk(i_clk), .i_we(hd_we & hd_wbank), .i_waddr(hd_waddr),
        .i_wdata(hd_wdata), .i_raddr(hd_raddr), .o_rdata(hd_q1)
    );

    // node pool
    chm_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_keys (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(nd_waddr),
        .i_wdata(r_cmd.key), .i_raddr(nd_raddr), .o_rdata(key_q)
    );
    chm_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_values (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(nd_waddr),
        .i_wdata(r_cmd.value), .i_raddr(nd_raddr), .o_rdata(val_q)
    );
    chm_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_hashes (
        .i_clk(i_clk), .i_we(hsh_we), .i_waddr(nd_waddr),
        .i_wdata(r_cmd.hash), .i_raddr(nd_raddr), .o_rdata(hsh_q)
    );
    chm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_links (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(nd_waddr),
        .i_wdata(lnk_wdata), .i_raddr(nd_raddr), .o_rdata(lnk_q)
    );
    chm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_free (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_waddr),
        .i_wdata(fs_wdata), .i_raddr(fs_raddr), .o_rdata(fs_q)
    );

endmodule

### design/chained_hash_map_engine_top.sv
`timescale 1ns / 1ps
// integer-keyed hash map with separate chaining
// command channel: i_in (kind, key, value) is taken at a clock edge with start high
// and busy low; kinds are put, get, remove and clear
// result channel: one result per command on o_res, shown for one cycle with
// o_res_valid high; the receiver cannot stall it, results come in command order
// config channel: i_cfg_data (initial bucket count) is written when i_cfg_valid
// is high; o_cfg_ready is always high; the value takes effect at the next clear
// processing: the key runs through the mixing hash and is handed over through the queue,
// the remainder unit picks the bucket, the head is read and the chain is walked node by
// node until a key match or the chain end, then the result is registered
// flow control: busy is high while a command is hashed, so a new command can be taken
// after hashing ends while the two-entry queue has room; the back end takes one at a time
// a put that grows the table clears the new head bank, then walks every old bucket,
// moves every node into the new bank and looks up again
// clear sweeps the tables over max(MAX_BUCKETS, MAX_NODES) entries (8192 by default)
// after reset the same sweep runs with busy held high; then the map is empty
module chained_hash_map_engine_top #(
    parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_NODES   = chm_pkg::MAX_NODES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  chm_pkg::t_in               i_in,
    output logic                       o_res_valid,
    output chm_pkg::t_out              o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [chm_pkg::INIT_W-1:0] i_cfg_data
);

    logic [chm_pkg::INIT_W-1:0] r_init_buckets;
    logic                       q_valid;
    chm_pkg::t_cmd              q_cmd;
    logic                       q_pop;
    logic                       be_init;

    assign o_cfg_ready = 1'b1;

    // initial bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_buckets <= chm_pkg::INIT_W'(chm_pkg::DEFAULT_BUCKETS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_init_buckets <= i_cfg_data;
        end
    end

    chm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_hold    (be_init),
        .i_in      (i_in),
        .o_busy    (busy),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    chm_back #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_NODES   (MAX_NODES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_init_buckets (r_init_buckets),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (q_pop),
        .o_init         (be_init),
        .o_res_valid    (o_res_valid),
        .o_res          (o_res)
    );

endmodule

### design/chm_checker.sv
`timescale 1ns / 1ps

module chm_props (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input chm_pkg::t_in               i_in,
    input logic                       o_res_valid,
    input chm_pkg::t_out              o_res,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [chm_pkg::INIT_W-1:0] i_cfg_data
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result strobe after reset");

    // a refused insert never reports a present key
    a_no_room_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == chm_pkg::STATUS_NO_ROOM) |-> !o_res.found)
        else $error("no_room with key found");

    // a nonzero read value only comes from a hit
    a_value_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.read_value != '0) |-> o_res.found)
        else $error("read value without hit");

    // an accepted transaction keeps the block busy while it is hashed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accept");

endmodule

bind chained_hash_map_engine_top chm_props u_chk (.*);

### test/chm_checker.sv
`timescale 1ns / 1ps

module chm_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  chm_pkg::t_in               i_in,
    input  logic                       i_res_valid,
    input  chm_pkg::t_out              i_res,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [chm_pkg::INIT_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    // shadow copy of the map contents and sizing
    logic [31:0]                shadow_map [logic [31:0]];
    int unsigned                shadow_entries;
    int unsigned                shadow_buckets;
    logic [chm_pkg::INIT_W-1:0] shadow_init;
    chm_pkg::t_out              expected_results [$];
    int                         fails;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        fails++;
    endtask

    function automatic int unsigned load_buckets(input logic [chm_pkg::INIT_W-1:0] v);
        if (v == 0) return chm_pkg::DEFAULT_BUCKETS;
        if (v > chm_pkg::MAX_BUCKETS_DEF) return chm_pkg::MAX_BUCKETS_DEF;
        return 32'(v);
    endfunction

    // apply one command to the shadow map and return its result
    function automatic chm_pkg::t_out apply_command(input chm_pkg::t_in cmd);
        chm_pkg::t_out r;
        int unsigned   grown;
        r = '0;
        case (chm_pkg::t_kind'(cmd.kind))
            chm_pkg::K_CLEAR: begin
                shadow_map.delete();
                shadow_entries = 0;
                shadow_buckets = load_buckets(shadow_init);
            end
            chm_pkg::K_GET: begin
                if (shadow_map.exists(cmd.key)) begin
                    r.found      = 1'b1;
                    r.read_value = shadow_map[cmd.key];
                end
            end
            chm_pkg::K_REMOVE: begin
                if (shadow_map.exists(cmd.key)) begin
                    r.found = 1'b1;
                    shadow_map.delete(cmd.key);
                    shadow_entries--;
                end
            end
            default: begin
                if (shadow_map.exists(cmd.key)) begin
                    r.found = 1'b1;
                    shadow_map[cmd.key] = cmd.value;
                end else if (shadow_entries >= chm_pkg::MAX_NODES_DEF) begin
                    r.status = chm_pkg::STATUS_NO_ROOM;
                end else begin
                    grown = shadow_buckets;
                    if (shadow_entries + 1 > ((shadow_buckets * 3) >> 2))
                        grown = shadow_buckets * 2 + 1;
                    if (grown > chm_pkg::MAX_BUCKETS_DEF) begin
                        r.status = chm_pkg::STATUS_NO_ROOM;
                    end else begin
                        shadow_buckets = grown;
                        shadow_map[cmd.key] = cmd.value;
                        shadow_entries++;
                    end
                end
            end
        endcase
        r.entry_count = shadow_entries[chm_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // watch config, command and result transactions
    always @(posedge i_clk) begin
        chm_pkg::t_out want;
        if (!i_rst_n) begin
            shadow_map.delete();
            shadow_entries = 0;
            shadow_init    = chm_pkg::INIT_W'(chm_pkg::DEFAULT_BUCKETS);
            shadow_buckets = chm_pkg::DEFAULT_BUCKETS;
            expected_results.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                shadow_init = i_cfg_data;
            if (i_res_valid) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result at %0t", $time);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.found !== want.found)
                        report_mismatch("found", 32'(i_res.found), 32'(want.found));
                    if (i_res.read_value !== want.read_value)
                        report_mismatch("read_value", i_res.read_value, want.read_value);
                    if (i_res.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(i_res.entry_count),
                                        32'(want.entry_count));
                    if (i_res.status !== want.status)
                        report_mismatch("status", 32'(i_res.status), 32'(want.status));
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(apply_command(i_in));
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

### test/chained_hash_map_engine_top_tb.sv
`timescale 1ns / 1ps

module chained_hash_map_engine_top_tb;

    localparam int CYCLE_LIMIT = 1500000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    chm_pkg::t_in               i_in;
    logic                       o_res_valid;
    chm_pkg::t_out              o_res;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [chm_pkg::INIT_W-1:0] i_cfg_data;
    int                         fail_count;
    int                         pending;
    int                         cycles = 0;
    int                         gap_pct;
    logic [31:0]                key_pool [48];

    chained_hash_map_engine_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    chm_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_in        (i_in),
        .i_res_valid (o_res_valid),
        .i_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one command transaction, with a random idle gap in front
    task automatic issue(input chm_pkg::t_kind kind, input logic [31:0] key,
                         input logic [31:0] value);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= '{kind: kind, key: key, value: value};
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // config transaction, only while the map is idle
    task automatic write_init(input logic [chm_pkg::INIT_W-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int pct, input logic [chm_pkg::INIT_W-1:0] init,
                                input int count);
        int          r;
        logic [31:0] k;
        gap_pct = pct;
        write_init(init);
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        issue(chm_pkg::K_CLEAR, $urandom, $urandom);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(999);
            k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(47)];
            if (r < 4)        issue(chm_pkg::K_CLEAR, k, $urandom);
            else if (r < 450) issue(chm_pkg::K_PUT, k, $urandom);
            else if (r < 720) issue(chm_pkg::K_GET, k, $urandom);
            else              issue(chm_pkg::K_REMOVE, k, $urandom);
            // sender holds off until the map has answered everything
            if (n == count / 2) wait_drained();
        end
    endtask

    initial begin
        gap_pct     = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme keys and values, every kind
        issue(chm_pkg::K_PUT, 32'h0, 32'h0);
        issue(chm_pkg::K_PUT, 32'hffffffff, 32'hffffffff);
        issue(chm_pkg::K_GET, 32'h0, 32'h0);
        issue(chm_pkg::K_GET, 32'hffffffff, 32'h0);
        issue(chm_pkg::K_PUT, 32'h0, 32'hdeadbeef);
        issue(chm_pkg::K_GET, 32'h0, 32'hffffffff);
        issue(chm_pkg::K_REMOVE, 32'hffffffff, 32'h0);
        issue(chm_pkg::K_REMOVE, 32'hffffffff, 32'h0);
        issue(chm_pkg::K_GET, 32'h12345678, 32'h0);
        issue(chm_pkg::K_CLEAR, 32'h0, 32'h0);
        issue(chm_pkg::K_GET, 32'h0, 32'h0);
        // zero register loads the default bucket count
        write_init('0);
        issue(chm_pkg::K_CLEAR, 32'hffffffff, 32'hffffffff);
        issue(chm_pkg::K_PUT, 32'h1, 32'h1);
        // single bucket forces repeated growth
        write_init(13'd1);
        issue(chm_pkg::K_CLEAR, 32'h0, 32'h0);
        for (int i = 0; i < 8; i++) issue(chm_pkg::K_PUT, $urandom, $urandom);

        // random phases, sender gaps light, heavy, then none
        random_phase(30, 13'd1, 500);
        random_phase(70, 13'h1fff, 500);
        random_phase(0, 13'($urandom_range(2, 600)), 500);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
